// File: design/shbl_pkg.sv
// Shabal-256 constants, types and helper functions.
`default_nettype none
package shbl_pkg;
	localparam int unsigned WordW = 32;
	localparam int unsigned NumA = 12;
	localparam int unsigned NumB = 16;
	localparam int unsigned NumSteps = 48;
	localparam int unsigned NumRounds = 5;
	localparam int unsigned NumCfg = 4;
	localparam int unsigned CfgIdxW = 2;
	localparam logic [WordW-1:0] PadWord = 32'h0000_0080;

	typedef logic [WordW-1:0] word_t;
	typedef word_t [NumA-1:0] a_vec_t;
	typedef word_t [NumB-1:0] b_vec_t;

	typedef struct packed {
		logic [63:0] data_word0;
		logic [63:0] data_word1;
		logic [63:0] data_word2;
		logic [63:0] data_word3;
		logic [63:0] data_word4;
		logic [63:0] data_word5;
		logic [63:0] data_word6;
		logic [63:0] data_word7;
	} in_item_t;

	typedef struct packed {
		logic [63:0] hash_prefix;
	} out_item_t;

	// control from sequencer to the cell rows
	typedef struct packed {
		logic load;      // load initial state, add message into B
		logic step;      // one permutation step, rows shift by one
		logic pre;       // xor counter into A0, rotate B by 17
		logic fin;       // A += C terms; first round: C -= M, B += M2; swap B/C except in the last round
		logic sub_m;
		logic swap;
		logic [1:0] w;
	} ctl_t;

	localparam a_vec_t AInit = '{
		32'hEB21B74A, 32'hEFFDBC6B, 32'h22AF50DC, 32'h14CE5A45,
		32'hB0D2EB8C, 32'hD2B5C1CA, 32'hBB7C44C9, 32'hE0078B86,
		32'hB9645191, 32'h2D8EE3EC, 32'hE54B7999, 32'h52F84552};
	localparam b_vec_t BInit = '{
		32'h55CB34A5, 32'h30924DD4, 32'h3299ACE4, 32'h3EA8B96B,
		32'hB38B8890, 32'hBE216306, 32'h5138C1D4, 32'hA6E03615,
		32'h0AFE4002, 32'h9CB6BF72, 32'h696FD868, 32'hDA28C1FA,
		32'h9301515F, 32'hA72A652F, 32'h3E710596, 32'hB555C6EE};
	localparam b_vec_t CInit = '{
		32'h9B491C60, 32'hBA839E55, 32'hE6E00BF7, 32'hBC968828,
		32'h83E82A7F, 32'h758B4B8B, 32'h60E2CEBA, 32'h88B59D60,
		32'hED614433, 32'h56C56167, 32'hA327B8E1, 32'hC51C28AE,
		32'hC0DD9D55, 32'hB3733979, 32'hC4233EBA, 32'hB405F031};

	function automatic word_t rotl(input word_t x, input int unsigned n);
		rotl = (x << n) | (x >> (WordW - n));
	endfunction
endpackage
`default_nettype wire

// File: design/shbl_if.sv
// Valid/ready channel carrying one payload word.
`default_nettype none
interface shbl_if #(parameter type T = logic) ();
	logic valid;
	logic ready;
	T payload;
	modport source(output valid, output payload, input ready);
	modport sink(input valid, input payload, output ready);
endinterface
`default_nettype wire

// File: design/shbl_cell.sv
// One storage cell of a rotating word row: holds a word, passes it on.
`default_nettype none
module shbl_cell (
	input wire logic clk,
	input wire logic en,
	input wire shbl_pkg::word_t d,
	output shbl_pkg::word_t q
);
	import shbl_pkg::*;
	word_t val_q;
	always_ff @(posedge clk) begin
		if (en) val_q <= d;
	end
	assign q = val_q;
endmodule
`default_nettype wire

// File: design/shbl_core.sv
// Shabal state as rows of shifting cells plus the step datapath and sequencer.
`default_nettype none
module shbl_core (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire shbl_pkg::b_vec_t m1,
	input wire shbl_pkg::b_vec_t m2,
	output logic busy,
	output logic done,
	output logic [63:0] result
);
	import shbl_pkg::*;

	typedef enum logic [4:0] {
		S_IDLE = 5'b00001, S_PRE = 5'b00010, S_STEP = 5'b00100,
		S_FIN = 5'b01000, S_LOAD = 5'b10000
	} st_t;

	st_t st_q;
	logic [5:0] step_q;
	logic [2:0] rnd_q;
	ctl_t ctl;

	a_vec_t a_cur, a_nxt;
	b_vec_t b_cur, b_nxt, c_cur, c_nxt;
	b_vec_t m_row_q;
	logic en;

	// cell rows: A and B each shift left by one position per step, C rotates right by one
	for (genvar i = 0; i < NumA; i++) begin : g_a
		shbl_cell u_c (.clk(clk), .en(en), .d(a_nxt[i]), .q(a_cur[i]));
	end
	for (genvar i = 0; i < NumB; i++) begin : g_bc
		shbl_cell u_b (.clk(clk), .en(en), .d(b_nxt[i]), .q(b_cur[i]));
		shbl_cell u_cc (.clk(clk), .en(en), .d(c_nxt[i]), .q(c_cur[i]));
	end

	b_vec_t m_cur;
	assign m_cur = (rnd_q == 3'd0) ? m1 : m2;

	always_comb begin
		ctl = '0;
		ctl.load = (st_q == S_LOAD);
		ctl.pre = (st_q == S_PRE);
		ctl.step = (st_q == S_STEP);
		ctl.fin = (st_q == S_FIN);
		ctl.sub_m = (rnd_q == 3'd0);
		ctl.swap = (rnd_q != 3'(NumRounds - 1));
		ctl.w = (rnd_q == 3'd0) ? 2'd1 : 2'd2;
	end
	assign en = ctl.load | ctl.pre | ctl.step | ctl.fin;

	// A and B rows are kept rotated so position 0 always holds the element being updated
	word_t t, na, nb;
	always_comb begin
		a_nxt = a_cur; b_nxt = b_cur; c_nxt = c_cur;
		t = '0; na = '0; nb = '0;
		if (ctl.load) begin
			a_nxt = AInit; c_nxt = CInit;
			for (int i = 0; i < NumB; i++) b_nxt[i] = BInit[i] + m1[i];
		end else if (ctl.pre) begin
			a_nxt[0] = a_cur[0] ^ {30'd0, ctl.w};
			for (int i = 0; i < NumB; i++) b_nxt[i] = rotl(b_cur[i], 17);
		end else if (ctl.step) begin
			// a row: [0]=A[xa0], [11]=A[xa1]; b row: [0]=B[xb0]; c row: [8]=C[24-j]
			t = rotl(a_cur[NumA-1], 15) * 5;
			na = ((a_cur[0] ^ t ^ c_cur[8]) * 3) ^ b_cur[13]
				^ (b_cur[9] & ~b_cur[6]) ^ m_row_q[0];
			nb = ~(rotl(b_cur[0], 1) ^ na);
			for (int i = 0; i < NumA - 1; i++) a_nxt[i] = a_cur[i+1];
			a_nxt[NumA-1] = na;
			for (int i = 0; i < NumB - 1; i++) b_nxt[i] = b_cur[i+1];
			b_nxt[NumB-1] = nb;
			// C index 24-j moves down one per step: rotate C right
			for (int i = 1; i < NumB; i++) c_nxt[i] = c_cur[i-1];
			c_nxt[0] = c_cur[NumB-1];
		end else if (ctl.fin) begin
			// after 48 steps A and B are back in natural order, C rotated by 48
			for (int i = 0; i < NumA; i++)
				a_nxt[i] = a_cur[i] + c_cur[(i+11+NumB) % NumB] + c_cur[(i+15) % NumB]
					+ c_cur[(i+3) % NumB];
			if (ctl.sub_m)
				for (int i = 0; i < NumB; i++) c_nxt[i] = c_cur[i] - m1[i];
			if (ctl.swap) begin
				b_nxt = ctl.sub_m ? c_nxt : c_cur;
				c_nxt = b_cur;
				if (ctl.sub_m)
					for (int i = 0; i < NumB; i++) b_nxt[i] = b_nxt[i] + m2[i];
			end
		end
	end

	// C row is rotated by 48 = 0 mod 16 after a round; index fix above is identity

	always_ff @(posedge clk) begin
		if (ctl.pre) m_row_q <= m_cur;
		else if (ctl.step) m_row_q <= {m_row_q[0], m_row_q[NumB-1:1]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE; step_q <= '0; rnd_q <= '0; done <= 1'b0;
		end else begin
			done <= 1'b0;
			unique case (st_q)
				S_IDLE: if (start) begin st_q <= S_LOAD; rnd_q <= '0; end
				S_LOAD: st_q <= S_PRE;
				S_PRE: begin st_q <= S_STEP; step_q <= '0; end
				S_STEP: begin
					if (step_q == 6'(NumSteps - 1)) st_q <= S_FIN;
					step_q <= step_q + 6'd1;
				end
				S_FIN: begin
					if (rnd_q == 3'(NumRounds - 1)) begin st_q <= S_IDLE; done <= 1'b1; end
					else begin st_q <= S_PRE; rnd_q <= rnd_q + 3'd1; end
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end

	assign busy = (st_q != S_IDLE);
	assign result = {b_cur[9], b_cur[8]};

	a_busy_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> st_q == S_IDLE) else $error("done outside idle");
	a_step_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == S_FIN) |-> step_q == 6'(NumSteps)) else $error("bad step count");
	a_start: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == S_IDLE && start) |=> st_q == S_LOAD) else $error("start lost");
endmodule
`default_nettype wire

// File: design/shabal256_fixed_message_hash.sv
// Shabal-256 prefix of a fixed 96-byte message: top level.
// One word at a time: a new word is accepted only after the previous one finishes;
// the core runs a single permutation step per cycle over the cell rows.
// Output register holds a result until taken; input waits while it is full.
// Reset (arst_n low) clears the signature registers to zero and returns control to idle.
`default_nettype none
module shabal256_fixed_message_hash (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_we,
	input wire logic [shbl_pkg::CfgIdxW-1:0] cfg_index,
	input wire logic [63:0] cfg_data,
	shbl_if.sink in_ch,
	shbl_if.source out_ch
);
	import shbl_pkg::*;

	logic [63:0] sig_q [NumCfg];
	b_vec_t m1, m2;
	in_item_t item_q;
	logic busy, done, start;
	logic [63:0] res;
	logic ov_q;
	logic [63:0] ob_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NumCfg; i++) sig_q[i] <= '0;
		end else if (cfg_we) begin
			sig_q[cfg_index] <= cfg_data;
		end
	end

	// a new word only starts once the output register is free
	assign in_ch.ready = !busy && !start && !done && (!ov_q || out_ch.ready);
	logic acc_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) acc_q <= 1'b0;
		else acc_q <= in_ch.valid && in_ch.ready;
	end
	assign start = acc_q;
	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready) item_q <= in_ch.payload;
	end

	always_comb begin
		for (int i = 0; i < NumCfg; i++) begin
			m1[2*i] = sig_q[i][31:0];
			m1[2*i+1] = sig_q[i][63:32];
		end
		{m1[15], m1[14]} = item_q.data_word3;
		{m1[13], m1[12]} = item_q.data_word2;
		{m1[11], m1[10]} = item_q.data_word1;
		{m1[9], m1[8]} = item_q.data_word0;
		{m2[1], m2[0]} = item_q.data_word4;
		{m2[3], m2[2]} = item_q.data_word5;
		{m2[5], m2[4]} = item_q.data_word6;
		{m2[7], m2[6]} = item_q.data_word7;
		for (int i = 8; i < NumB; i++) m2[i] = '0;
		m2[8] = PadWord;
	end

	shbl_core u_core (.clk(clk), .arst_n(arst_n), .start(start), .m1(m1), .m2(m2),
		.busy(busy), .done(done), .result(res));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) ov_q <= 1'b0;
		else if (done) ov_q <= 1'b1;
		else if (out_ch.ready) ov_q <= 1'b0;
	end
	always_ff @(posedge clk) begin
		if (done) ob_q <= res;
	end
	assign out_ch.valid = ov_q;
	assign out_ch.payload.hash_prefix = ob_q;

	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !ov_q || out_ch.ready) else $error("result overwritten");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(ov_q && !out_ch.ready) |=> $stable(ob_q)) else $error("result changed");
	a_accept_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(in_ch.valid && in_ch.ready) |=> start) else $error("no start");
endmodule
`default_nettype wire

// File: test/tb_shabal256_fixed_message_hash.sv
// Testbench for the Shabal-256 fixed-message hash prefix block.
`default_nettype none
module tb_shabal256_fixed_message_hash;
	timeunit 1ns;
	timeprecision 1ps;
	import shbl_pkg::*;

	localparam int unsigned CycleLimit = 5_000_000;
	localparam int unsigned DrainCycles = 300;
	localparam int unsigned LongHold = 3000;

	localparam logic [CfgIdxW-1:0] RegSig0 = 2'd0;
	localparam logic [CfgIdxW-1:0] RegSig1 = 2'd1;
	localparam logic [CfgIdxW-1:0] RegSig2 = 2'd2;
	localparam logic [CfgIdxW-1:0] RegSig3 = 2'd3;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CfgIdxW-1:0] cfg_index;
	logic [63:0] cfg_data;

	shbl_if #(.T(in_item_t)) in_ch ();
	shbl_if #(.T(out_item_t)) out_ch ();

	shabal256_fixed_message_hash u_top (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_ch(in_ch.sink),
		.out_ch(out_ch.source)
	);

	logic [63:0] signature [4];
	logic [63:0] prefix_q [$];
	int unsigned error_cnt;
	int unsigned cycle_cnt;
	logic hold_req;

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// ---------------- predictor ----------------
	function automatic word_t rol(input word_t x, input int unsigned n);
		logic [63:0] d;
		d = {x, x} << n;
		rol = d[63:32];
	endfunction

	function automatic void permute(inout word_t a [12], inout word_t b [16],
			input word_t c [16], input word_t m [16], input word_t w);
		int unsigned xa0, xa1, xb0;
		word_t t;
		a[0] = a[0] ^ w;
		for (int i = 0; i < 16; i++)
			b[i] = rol(b[i], 17);
		for (int j = 0; j < 48; j++) begin
			xa0 = j % 12;
			xa1 = (j + 11) % 12;
			xb0 = j & 15;
			t = rol(a[xa1], 15) * 32'd5;
			a[xa0] = ((a[xa0] ^ t ^ c[(24 - xb0) & 15]) * 32'd3) ^ b[(j + 13) & 15]
				^ (b[(j + 9) & 15] & ~b[(j + 6) & 15]) ^ m[xb0];
			b[xb0] = ~(rol(b[xb0], 1) ^ a[xa0]);
		end
		for (int i = 0; i < 12; i++)
			a[i] = a[i] + c[(i + 11) & 15] + c[(i + 15) & 15] + c[(i + 3) & 15];
	endfunction

	function automatic void swap_bc(inout word_t b [16], inout word_t c [16]);
		word_t t;
		for (int i = 0; i < 16; i++) begin
			t = b[i];
			b[i] = c[i];
			c[i] = t;
		end
	endfunction

	function automatic logic [63:0] hash_prefix_of(input in_item_t it);
		word_t a [12];
		word_t b [16];
		word_t c [16];
		word_t m1 [16];
		word_t m2 [16];
		logic [63:0] d [8];
		d = '{it.data_word0, it.data_word1, it.data_word2, it.data_word3,
			it.data_word4, it.data_word5, it.data_word6, it.data_word7};
		for (int i = 0; i < 4; i++) begin
			m1[2*i] = signature[i][31:0];
			m1[2*i+1] = signature[i][63:32];
			m1[8+2*i] = d[i][31:0];
			m1[9+2*i] = d[i][63:32];
			m2[2*i] = d[4+i][31:0];
			m2[2*i+1] = d[4+i][63:32];
		end
		for (int i = 8; i < 16; i++)
			m2[i] = '0;
		m2[8] = PadWord;
		for (int i = 0; i < 12; i++)
			a[i] = AInit[i];
		for (int i = 0; i < 16; i++) begin
			b[i] = BInit[i] + m1[i];
			c[i] = CInit[i];
		end
		permute(a, b, c, m1, 32'd1);
		for (int i = 0; i < 16; i++)
			c[i] = c[i] - m1[i];
		swap_bc(b, c);
		for (int i = 0; i < 16; i++)
			b[i] = b[i] + m2[i];
		permute(a, b, c, m2, 32'd2);
		// final rounds keep the counter at 2
		for (int r = 0; r < 3; r++) begin
			swap_bc(b, c);
			permute(a, b, c, m2, 32'd2);
		end
		return {b[9], b[8]};
	endfunction

	// ---------------- result checking ----------------
	always @(posedge clk) begin
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (prefix_q.size() == 0) begin
				$error("unexpected word: hash_prefix=%h", out_ch.payload.hash_prefix);
				error_cnt++;
			end else begin
				logic [63:0] exp_prefix;
				exp_prefix = prefix_q.pop_front();
				if (out_ch.payload.hash_prefix !== exp_prefix) begin
					$error("hash_prefix: expected %h, got %h", exp_prefix,
						out_ch.payload.hash_prefix);
					error_cnt++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt > CycleLimit) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// ---------------- receiver stalls ----------------
	initial begin
		int unsigned hold_left;
		int unsigned mode;
		hold_left = 0;
		out_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req && hold_left == 0) begin
				hold_left = LongHold;
				hold_req <= 1'b0;
			end
			mode = (cycle_cnt / 5000) % 3;
			if (hold_left != 0) begin
				hold_left--;
				out_ch.ready <= 1'b0;
			end else if (mode == 0)
				out_ch.ready <= 1'b1;
			else if (mode == 1)
				out_ch.ready <= ($urandom_range(0, 99) < 60);
			else
				out_ch.ready <= ((cycle_cnt % 7) < 2);
		end
	end

	// ---------------- sender ----------------
	int unsigned burst_left;

	task automatic send_word(input in_item_t it);
		int unsigned gap;
		in_ch.valid <= 1'b1;
		in_ch.payload <= it;
		do
			@(posedge clk);
		while (!in_ch.ready);
		prefix_q.push_back(hash_prefix_of(it));
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 8);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 300);
			if (gap != 0) begin
				in_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end else
			burst_left--;
	endtask

	task automatic drop_valid();
		in_ch.valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic wait_idle();
		while (prefix_q.size() != 0)
			@(posedge clk);
		repeat (DrainCycles) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [63:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		signature[idx] = val;
	endtask

	task automatic set_signature(input logic [63:0] s0, input logic [63:0] s1,
			input logic [63:0] s2, input logic [63:0] s3);
		wait_idle();
		write_reg(RegSig0, s0);
		write_reg(RegSig1, s1);
		write_reg(RegSig2, s2);
		write_reg(RegSig3, s3);
		@(posedge clk);
	endtask

	function automatic logic [63:0] rand64();
		logic [63:0] v;
		case ($urandom_range(0, 5))
			0: v = '0;
			1: v = '1;
			2: v = 64'd1 << $urandom_range(0, 63);
			3: v = ~(64'd1 << $urandom_range(0, 63));
			default: v = {$urandom, $urandom};
		endcase
		return v;
	endfunction

	function automatic in_item_t rand_item();
		in_item_t it;
		it = '{rand64(), rand64(), rand64(), rand64(),
			rand64(), rand64(), rand64(), rand64()};
		return it;
	endfunction

	// ---------------- tests ----------------
	task automatic test_directed();
		in_item_t it;
		send_word('0);
		send_word('1);
		send_word({8{64'hAAAA_AAAA_AAAA_AAAA}});
		send_word({8{64'h5555_5555_5555_5555}});
		for (int k = 0; k < 8; k++) begin
			it = '0;
			it[64*k +: 64] = 64'h8000_0000_0000_0001;
			send_word(it);
		end
		send_word({64'h0123_4567_89AB_CDEF, {7{64'hFEDC_BA98_7654_3210}}});
		drop_valid();
	endtask

	task automatic test_random(input int unsigned count);
		for (int unsigned n = 0; n < count; n++)
			send_word(rand_item());
		drop_valid();
	endtask

	task automatic test_output_backpressure();
		wait_idle();
		hold_req <= 1'b1;
		burst_left = 20;
		for (int n = 0; n < 12; n++)
			send_word(rand_item());
		drop_valid();
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_ch.valid = 1'b0;
		in_ch.payload = '0;
		hold_req = 1'b0;
		error_cnt = 0;
		cycle_cnt = 0;
		burst_left = 0;
		for (int i = 0; i < 4; i++)
			signature[i] = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// signature still at its reset value
		test_directed();
		test_random(300);

		set_signature('1, '1, '1, '1);
		test_directed();
		test_random(300);
		test_output_backpressure();

		set_signature(64'hAAAA_AAAA_5555_5555, 64'h0, 64'hFFFF_FFFF_0000_0000,
			64'h0000_0001_8000_0000);
		test_random(300);

		for (int p = 0; p < 3; p++) begin
			set_signature(rand64(), rand64(), rand64(), rand64());
			test_random(330);
		end

		wait_idle();
		if (error_cnt == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end
endmodule
`default_nettype wire
